@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion with asynchronous active-low reset disable.
`define TIRT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tirt assertion failed");
// Non-overlapping implication check that a stalled signal holds.
`define TIRT_ASSERT_HOLD(label, clk, rst_n, cond, sig) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        cond |=> $stable(sig)) else $error("tirt hold check failed");
`endif

@@ rtl/tirt_pkg.sv @@
// Shared types and constants of the time interval reservation table.
// Depends on nothing.
package tirt_pkg;
    localparam int TIME_W   = 16;
    localparam int KEY_IN_W = 8;
    localparam int CNT_W    = 4;
    localparam int STAT_W   = 2;
    localparam int IN_DW    = 56;
    localparam int OUT_DW   = 40;

    localparam logic       FUNC_INSERT = 1'b0;
    localparam logic       FUNC_QUERY  = 1'b1;
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_BAD    = 2'd2;

    typedef struct packed {
        logic capture;
        logic calc;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_hold;
    } dp_status_t;
endpackage

@@ rtl/tirt_ctrl.sv @@
// Controller state machine of the reservation table.
// Depends on tirt_pkg.
module tirt_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tirt_pkg::dp_status_t  stat,
    output tirt_pkg::ctrl_cmd_t   cmd
);
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CALC  = 3'b010,
        ST_WRITE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // hold while the previous result still waits
                if (!stat.out_hold)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

@@ rtl/tirt_dp.sv @@
// Datapath: row memory, merge/compaction logic and output register.
// Depends on tirt_pkg.
module tirt_dp
#(
    parameter int KEYS         = 256,
    parameter int SLOTS        = 8,
    parameter int TIME_FOREVER = 65535
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  tirt_pkg::ctrl_cmd_t          cmd,
    output tirt_pkg::dp_status_t         stat,
    input  logic                         in_func,
    input  logic [tirt_pkg::KEY_IN_W-1:0] in_key,
    input  logic [tirt_pkg::TIME_W-1:0]  in_start,
    input  logic [tirt_pkg::TIME_W-1:0]  in_end,
    input  logic [tirt_pkg::TIME_W-1:0]  in_query,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         out_blocked,
    output logic [tirt_pkg::STAT_W-1:0]  out_status,
    output logic [tirt_pkg::TIME_W-1:0]  out_latest,
    output logic [tirt_pkg::TIME_W-1:0]  out_extent
);
    localparam int TW    = tirt_pkg::TIME_W;
    localparam int CW    = tirt_pkg::CNT_W;
    localparam int KEY_W = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ROW_W = CW + 2 * SLOTS * TW;
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
    localparam logic [TW-1:0] FOREVER = TW'(TIME_FOREVER);

    logic [ROW_W-1:0] mem [KEYS];
    logic [KEYS-1:0]  vld_reg, vld_next;

    logic             func_reg;
    logic             key_ok_reg;
    logic [KEY_W-1:0] key_reg;
    logic [TW-1:0]    s_reg, e_reg, t_reg;
    logic [ROW_W-1:0] row_reg;
    logic             row_vld_reg;

    logic [TW-1:0]    old_s [SLOTS];
    logic [TW-1:0]    old_e [SLOTS];
    logic [CW-1:0]    raw_cnt, n;

    logic [TW-1:0]    new_s [SLOTS];
    logic [TW-1:0]    new_e [SLOTS];
    logic [CW-1:0]    new_cnt;
    logic [CW-1:0]    n_below, n_ov;
    logic [TW-1:0]    ns, ne;
    logic             hit;
    logic [CW:0]      src;
    logic [1:0]       calc_status;
    logic             calc_wr;
    logic [TW-1:0]    calc_latest;
    logic [ROW_W-1:0] calc_row;

    logic [ROW_W-1:0] wr_row_reg;
    logic             wr_en_reg;
    logic [1:0]       res_status_reg;
    logic             res_blocked_reg;
    logic [TW-1:0]    res_latest_reg;

    logic [TW-1:0]    latest_reg, latest_next;
    logic [TW-1:0]    extent_reg, extent_next;
    logic             out_valid_reg, out_valid_next;

    // capture, memory read and row write-back
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg   <= in_func;
            key_reg    <= KEY_W'(in_key);
            key_ok_reg <= (32'(in_key) < KEYS);
            s_reg      <= in_start;
            e_reg      <= in_end;
            t_reg      <= in_query;
            row_reg    <= mem[KEY_W'(in_key)];
        end
        if (cmd.commit && wr_en_reg)
        begin
            mem[key_reg] <= wr_row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            row_vld_reg <= vld_reg[KEY_W'(in_key)];
        end
    end

    always_comb
    begin
        for (int k = 0; k < SLOTS; k++)
        begin
            old_s[k] = row_reg[k*TW +: TW];
            old_e[k] = row_reg[(SLOTS + k)*TW +: TW];
        end
        raw_cnt = row_reg[ROW_W-1 -: CW];
        if (!row_vld_reg)
        begin
            n = '0;
        end
        else if (raw_cnt > SLOTS_C)
        begin
            n = SLOTS_C;
        end
        else
        begin
            n = raw_cnt;
        end
    end

    // merge, compaction, point test, status and latest time over the slot row
    always_comb
    begin
        n_below = '0;
        n_ov    = '0;
        ns      = s_reg;
        ne      = e_reg;
        hit     = 1'b0;
        for (int k = 0; k < SLOTS; k++)
        begin
            if (CW'(k) < n)
            begin
                if (old_e[k] < s_reg)
                begin
                    n_below = n_below + 1'b1;
                end
                else if (old_s[k] <= e_reg)
                begin
                    n_ov = n_ov + 1'b1;
                    if (old_s[k] < ns)
                    begin
                        ns = old_s[k];
                    end
                    if (old_e[k] > ne)
                    begin
                        ne = old_e[k];
                    end
                end
                if (old_s[k] <= t_reg && t_reg < old_e[k])
                begin
                    hit = 1'b1;
                end
            end
        end
        for (int w = 0; w < SLOTS; w++)
        begin
            src = (CW+1)'(w) + {1'b0, n_ov} - 1'b1;
            if (CW'(w) < n_below)
            begin
                new_s[w] = old_s[w];
                new_e[w] = old_e[w];
            end
            else if (CW'(w) == n_below)
            begin
                new_s[w] = ns;
                new_e[w] = ne;
            end
            else if (src < (CW+1)'(SLOTS))
            begin
                new_s[w] = old_s[src[IDX_W-1:0]];
                new_e[w] = old_e[src[IDX_W-1:0]];
            end
            else
            begin
                new_s[w] = '0;
                new_e[w] = '0;
            end
        end
        new_cnt = n - n_ov + 1'b1;
        for (int k = 0; k < SLOTS; k++)
        begin
            calc_row[k*TW +: TW]           = new_s[k];
            calc_row[(SLOTS + k)*TW +: TW] = new_e[k];
        end
        calc_row[ROW_W-1 -: CW] = new_cnt;

        calc_status = tirt_pkg::STAT_OK;
        calc_wr     = 1'b0;
        calc_latest = latest_reg;
        if (func_reg == tirt_pkg::FUNC_INSERT)
        begin
            if (e_reg <= s_reg)
            begin
                calc_status = tirt_pkg::STAT_BAD;
            end
            else if (!key_ok_reg || (n_ov == '0 && n >= SLOTS_C))
            begin
                calc_status = tirt_pkg::STAT_FULL;
            end
            else
            begin
                calc_wr = 1'b1;
                if (e_reg < FOREVER)
                begin
                    if (e_reg > latest_reg)
                    begin
                        calc_latest = e_reg;
                    end
                end
                else if (e_reg == FOREVER)
                begin
                    if (s_reg > latest_reg)
                    begin
                        calc_latest = s_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            wr_row_reg      <= calc_row;
            res_status_reg  <= calc_status;
            res_blocked_reg <= (func_reg == tirt_pkg::FUNC_QUERY) && key_ok_reg && hit;
            res_latest_reg  <= calc_latest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_en_reg <= 1'b0;
        end
        else if (cmd.calc)
        begin
            wr_en_reg <= calc_wr;
        end
    end

    // commit of the valid bits, running times and output register
    always_comb
    begin
        vld_next       = vld_reg;
        latest_next    = latest_reg;
        extent_next    = extent_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
            if (wr_en_reg)
            begin
                vld_next[key_reg] = 1'b1;
                latest_next       = res_latest_reg;
                if (res_latest_reg > extent_reg)
                begin
                    extent_next = res_latest_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            latest_reg    <= '0;
            extent_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= vld_next;
            latest_reg    <= latest_next;
            extent_reg    <= extent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_blocked <= res_blocked_reg;
            out_status  <= res_status_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_latest    = latest_reg;
    assign out_extent    = extent_reg;
    assign stat.out_hold = out_valid_reg && !out_ready;
endmodule

@@ rtl/time_interval_reservation_table.sv @@
// Top level of the time interval reservation table.
// Depends on tirt_pkg, tirt_ctrl and tirt_dp.
//
// Usage:
//   Input stream s_axis_*: one transaction per item, an insert of an interval
//   [start, end) or a point query, both for one key. Output stream m_axis_*:
//   exactly one result transaction per input transaction, in order.
//   After acceptance an item steps through the controller states: the
//   accepting edge reads the key's whole slot row from the row memory, the
//   calc state registers the parallel compare and compaction of all slots,
//   the write state writes the row back and loads the result into the output
//   register. The controller steps through these three states for each item
//   before it accepts the next, so items are not overlapped.
//   The result register frees the input side: the next item is accepted
//   while a result still waits; a new result only stalls in its write-back
//   cycle until the receiver takes the previous one.
//   Reset empties every list at once through per-key valid bits and clears
//   latest time and extent; there is no clearing pass, items are accepted
//   as soon as reset is released. Slot contents are kept without reset.
//   While m_axis_tready is low, the output transaction holds its value.
module time_interval_reservation_table
#(
    parameter int KEYS         = 256,
    parameter int SLOTS        = 8,
    parameter int TIME_FOREVER = 65535
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [tirt_pkg::IN_DW-1:0]  s_axis_tdata,  // key, start_time, end_time, query_time
    input  logic                        s_axis_tuser,  // func
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [tirt_pkg::OUT_DW-1:0] m_axis_tdata,  // blocked, latest_time, extent, zero fill
    output logic [1:0]                  m_axis_tuser   // status
);
    tirt_pkg::ctrl_cmd_t  cmd;
    tirt_pkg::dp_status_t stat;
    logic                 blocked;
    logic [15:0]          latest, extent;

    tirt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tirt_dp
    #(
        .KEYS         (KEYS),
        .SLOTS        (SLOTS),
        .TIME_FOREVER (TIME_FOREVER)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_func     (s_axis_tuser),
        .in_key      (s_axis_tdata[7:0]),
        .in_start    (s_axis_tdata[23:8]),
        .in_end      (s_axis_tdata[39:24]),
        .in_query    (s_axis_tdata[55:40]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_blocked (blocked),
        .out_status  (m_axis_tuser),
        .out_latest  (latest),
        .out_extent  (extent)
    );

    // pack result fields, lowest first
    assign m_axis_tdata = {7'd0, extent, latest, blocked};
endmodule

@@ rtl/tirt_checker.sv @@
// Port-level checker of the reservation table, bound to the top level.
// Depends on assert_macros.svh and tirt_pkg.
`include "assert_macros.svh"
module tirt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    `TIRT_ASSERT_HOLD(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tdata)
    `TIRT_ASSERT(a_extent_ge_latest, clk, rst_n, m_axis_tvalid |-> (m_axis_tdata[32:17] >= m_axis_tdata[16:1]))
    `TIRT_ASSERT(a_status_code, clk, rst_n, m_axis_tvalid |-> (m_axis_tuser == tirt_pkg::STAT_OK || m_axis_tuser == tirt_pkg::STAT_FULL || m_axis_tuser == tirt_pkg::STAT_BAD))
    `TIRT_ASSERT(a_blocked_ok, clk, rst_n, (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tuser == tirt_pkg::STAT_OK))
    `TIRT_ASSERT(a_extent_mono, clk, rst_n, (m_axis_tvalid && m_axis_tready) |=> (m_axis_tdata[32:17] >= $past(m_axis_tdata[32:17])))
endmodule

bind time_interval_reservation_table tirt_checker u_tirt_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ tb/tb.sv @@
// Testbench of the time interval reservation table: directed and random
// inserts and queries checked against a predictor of the sorted interval lists.
// Depends on tirt_pkg and time_interval_reservation_table.
`timescale 1ns / 1ps

module tb;
    localparam int NKEYS   = 256;
    localparam int NSLOTS  = 8;
    localparam logic [15:0] FOREVER = 16'hFFFF;

    typedef struct packed {
        logic        blocked;
        logic [1:0]  status;
        logic [15:0] latest_time;
        logic [15:0] extent;
    } verdict_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // Predictor copy of the interval lists and the two running times
    logic [15:0] lo_tab [NKEYS][NSLOTS];
    logic [15:0] hi_tab [NKEYS][NSLOTS];
    int          fill_tab [NKEYS];
    logic [15:0] latest_q;
    logic [15:0] extent_q;

    verdict_t    verdicts_due[$];
    int          errors;
    int          n_items;
    int          n_inserts;
    int          n_queries;
    int          n_full;
    int          n_bad;
    int          n_hits;
    bit          hold_off;
    bit          rx_pause;

    time_interval_reservation_table u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),  // key, start_time, end_time, query_time
        .s_axis_tuser  (s_axis_tuser),  // func
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),  // blocked, latest_time, extent
        .m_axis_tuser  (m_axis_tuser)   // status
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Merge the new interval into the key's list, mirroring the block's rules
    function automatic logic [1:0] apply_insert(int k, logic [15:0] s, logic [15:0] e);
        int          n;
        int          i;
        int          j;
        int          w;
        logic [15:0] ns;
        logic [15:0] ne;
        logic [15:0] ts [NSLOTS];
        logic [15:0] te [NSLOTS];
        if (e <= s)
            return tirt_pkg::STAT_BAD;
        n = fill_tab[k];
        i = 0;
        while (i < n && hi_tab[k][i] < s)
            i++;
        ns = s;
        ne = e;
        j = i;
        while (j < n && lo_tab[k][j] <= ne)
        begin
            if (lo_tab[k][j] < ns)
                ns = lo_tab[k][j];
            if (hi_tab[k][j] > ne)
                ne = hi_tab[k][j];
            j++;
        end
        if (j == i && n >= NSLOTS)
            return tirt_pkg::STAT_FULL;
        w = 0;
        for (int m = 0; m < i; m++)
        begin
            ts[w] = lo_tab[k][m];
            te[w] = hi_tab[k][m];
            w++;
        end
        ts[w] = ns;
        te[w] = ne;
        w++;
        for (int m = j; m < n && w < NSLOTS; m++)
        begin
            ts[w] = lo_tab[k][m];
            te[w] = hi_tab[k][m];
            w++;
        end
        for (int m = 0; m < w; m++)
        begin
            lo_tab[k][m] = ts[m];
            hi_tab[k][m] = te[m];
        end
        fill_tab[k] = w;
        // A forever end constrains only its start
        if (e != FOREVER)
        begin
            if (e > latest_q)
                latest_q = e;
        end
        else if (s > latest_q)
            latest_q = s;
        if (latest_q > extent_q)
            extent_q = latest_q;
        return tirt_pkg::STAT_OK;
    endfunction

    function automatic logic point_reserved(int k, logic [15:0] t);
        for (int m = 0; m < fill_tab[k]; m++)
            if (lo_tab[k][m] <= t && t < hi_tab[k][m])
                return 1'b1;
        return 1'b0;
    endfunction

    // Offer one item after a random gap; hold it until the transaction is taken.
    // Returns at the falling edge after acceptance with valid still high.
    task automatic offer_item(logic fn, logic [7:0] k, logic [15:0] s, logic [15:0] e,
                              logic [15:0] t, bit gap_ok = 1);
        int       gap;
        verdict_t v;
        gap = 0;
        if (gap_ok && $urandom_range(0, 2) == 0)
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {t, e, s, k};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        v = '0;
        if (fn == tirt_pkg::FUNC_INSERT)
        begin
            v.status = apply_insert(k, s, e);
            n_inserts++;
            if (v.status == tirt_pkg::STAT_FULL)
                n_full++;
            if (v.status == tirt_pkg::STAT_BAD)
                n_bad++;
        end
        else
        begin
            v.blocked = point_reserved(k, t);
            n_queries++;
            if (v.blocked)
                n_hits++;
        end
        v.latest_time = latest_q;
        v.extent      = extent_q;
        verdicts_due.push_back(v);
        n_items++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected result has come
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Edge values of every field, touching and overlapping merges, bad intervals
    task automatic test_directed();
        offer_item(tirt_pkg::FUNC_QUERY, 8'd0, 16'd0, 16'd0, 16'd0);
        offer_item(tirt_pkg::FUNC_INSERT, 8'd0, 16'd10, 16'd10, 16'd0);  // empty interval
        offer_item(tirt_pkg::FUNC_INSERT, 8'd0, 16'd20, 16'd5, 16'd0);   // reversed interval
        offer_item(tirt_pkg::FUNC_INSERT, 8'd0, 16'd10, 16'd20, 16'd0);
        offer_item(tirt_pkg::FUNC_INSERT, 8'd0, 16'd20, 16'd30, 16'd0);  // touches on the right
        offer_item(tirt_pkg::FUNC_INSERT, 8'd0, 16'd2, 16'd10, 16'd0);   // touches on the left
        offer_item(tirt_pkg::FUNC_QUERY, 8'd0, 16'd0, 16'd0, 16'd2);
        offer_item(tirt_pkg::FUNC_QUERY, 8'd0, 16'd0, 16'd0, 16'd30);
        offer_item(tirt_pkg::FUNC_QUERY, 8'd0, 16'd0, 16'd0, 16'd29);
        offer_item(tirt_pkg::FUNC_INSERT, 8'd255, 16'd0, 16'd1, 16'd0);
        offer_item(tirt_pkg::FUNC_INSERT, 8'd255, 16'd65534, FOREVER, 16'd0); // forever end
        offer_item(tirt_pkg::FUNC_QUERY, 8'd255, 16'd0, 16'd0, 16'hFFFF);
        offer_item(tirt_pkg::FUNC_QUERY, 8'd255, 16'd0, 16'd0, 16'hFFFE);
        // Fill key 7 with eight separate intervals, then overflow and merge
        for (int m = 0; m < 8; m++)
            offer_item(tirt_pkg::FUNC_INSERT, 8'd7, 16'(100 + 10 * m),
                       16'(104 + 10 * m), 16'd0);
        offer_item(tirt_pkg::FUNC_INSERT, 8'd7, 16'd500, 16'd600, 16'd0); // list full
        offer_item(tirt_pkg::FUNC_INSERT, 8'd7, 16'd50, 16'd60, 16'd0);   // list full, front
        offer_item(tirt_pkg::FUNC_INSERT, 8'd7, 16'd103, 16'd125, 16'd0); // merges three
        offer_item(tirt_pkg::FUNC_QUERY, 8'd7, 16'd0, 16'd0, 16'd115);
        drain_results();
    endtask

    // Random traffic on a few hot keys so lists fill, merge and overflow
    task automatic test_random(int count);
        logic        fn;
        logic [7:0]  k;
        logic [15:0] s;
        logic [15:0] e;
        logic [15:0] t;
        for (int n = 0; n < count; n++)
        begin
            fn = ($urandom_range(0, 9) < 5) ? tirt_pkg::FUNC_INSERT : tirt_pkg::FUNC_QUERY;
            k  = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
            case ($urandom_range(0, 5))
                0:       s = 16'($urandom);
                1:       s = 16'($urandom_range(65000, 65535));
                default: s = 16'($urandom_range(0, 600));
            endcase
            case ($urandom_range(0, 9))
                0:       e = FOREVER;
                1:       e = 16'($urandom);
                2:       e = s;
                default: e = s + 16'($urandom_range(1, 40));
            endcase
            t = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 700));
            offer_item(fn, k, s, e, t);
        end
    endtask

    // Stall the receiver for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int n = 0; n < 20; n++)
            offer_item(tirt_pkg::FUNC_QUERY, 8'($urandom_range(0, 5)), 16'd0, 16'd0,
                       16'($urandom_range(0, 700)), 0);
        drain_results();
    endtask

    // Receiver readiness: random stalls, occasionally long, and one forced hold-off
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        rx_pause      = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                m_axis_tready <= 1'b0;
                repeat (150) @(negedge clk);
                hold_off = 1'b0;
            end
            else if (!rx_pause && $urandom_range(0, 3) == 0)
            begin
                stall = ($urandom_range(0, 12) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        verdict_t want;
        verdict_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.blocked     = m_axis_tdata[0];
            got.latest_time = m_axis_tdata[16:1];
            got.extent      = m_axis_tdata[32:17];
            got.status      = m_axis_tuser;
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: result with nothing expected: %h", $realtime, got);
                errors++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (got.blocked !== want.blocked)
                begin
                    $display("%0t: blocked expected %0d actual %0d", $realtime,
                             want.blocked, got.blocked);
                    errors++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $realtime,
                             want.status, got.status);
                    errors++;
                end
                if (got.latest_time !== want.latest_time)
                begin
                    $display("%0t: latest_time expected %0d actual %0d", $realtime,
                             want.latest_time, got.latest_time);
                    errors++;
                end
                if (got.extent !== want.extent)
                begin
                    $display("%0t: extent expected %0d actual %0d", $realtime,
                             want.extent, got.extent);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #50ms;
        $display("tb failed");
        $finish;
    end

    initial
    begin
        errors        = 0;
        n_items       = 0;
        n_inserts     = 0;
        n_queries     = 0;
        n_full        = 0;
        n_bad         = 0;
        n_hits        = 0;
        hold_off      = 1'b0;
        latest_q      = '0;
        extent_q      = '0;
        for (int k = 0; k < NKEYS; k++)
            fill_tab[k] = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = tirt_pkg::FUNC_INSERT;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(350);
        test_backpressure();
        drain_results();      // sender pauses until every result has come
        test_random(360);
        drain_results();

        $display("Covered %0d transactions: %0d inserts (%0d full, %0d bad), %0d queries (%0d hit).",
                 n_items, n_inserts, n_full, n_bad, n_queries, n_hits);
        if (errors == 0 && verdicts_due.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
